// ===== rtl/assert_macros.svh =====
// Assertion macros used by sorted_timer_queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: label");

// When the condition holds, the consequence holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("assertion failed: label");

`endif

// ===== rtl/stq_pkg.sv =====
package stq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 64;
   localparam int TICK_W = 32;
   localparam int ID_W = 32;

   typedef enum logic [1:0] {
      OP_SCHEDULE = 2'd0,
      OP_CANCEL   = 2'd1,
      OP_POP      = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Command broadcast to every cell in the cycle a request is accepted.
   typedef struct packed {
      logic              insert;
      logic              remove;
      logic              pop;
      logic [TICK_W-1:0] deadline;
      logic [ID_W-1:0]   new_id;
      logic [ID_W-1:0]   timer_id;
   } cell_cmd_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic [TICK_W-1:0] deadline;
      logic [ID_W-1:0]   timer_id;
      logic              later;
   } cell_link_type;

   // One result held in the output stages.
   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   result_id;
      logic [TICK_W-1:0] result_deadline;
   } rsp_type;

endpackage

// ===== rtl/stq_cell.sv =====
module stq_cell
   import stq_pkg::*;
(
   input  logic          clock,
   input  cell_cmd_type  cmd,
   input  logic          cell_valid,
   input  cell_link_type left_link,
   input  cell_link_type right_link,
   input  logic          hit_in,
   output cell_link_type self_link,
   output logic          hit_out,
   output logic          first_hit
);

   logic [TICK_W-1:0] deadline_ff, deadline_in;
   logic [ID_W-1:0]   timer_id_ff, timer_id_in;
   logic              later;
   logic              hit_self;
   logic              hit_through;

   // An empty cell counts as later than any deadline, so inserts land there.
   always_comb begin
      later       = !cell_valid || (deadline_ff > cmd.deadline);
      hit_self    = cell_valid && (timer_id_ff == cmd.timer_id);
      hit_through = hit_in || hit_self;
      hit_out     = hit_through;
      first_hit   = hit_self && !hit_in;
      self_link.deadline = deadline_ff;
      self_link.timer_id = timer_id_ff;
      self_link.later    = later;
   end

   // Shift right on insert behind a later neighbor, left on removal.
   always_comb begin
      deadline_in = deadline_ff;
      timer_id_in = timer_id_ff;
      if (cmd.insert) begin
         if (left_link.later) begin
            deadline_in = left_link.deadline;
            timer_id_in = left_link.timer_id;
         end else if (later) begin
            deadline_in = cmd.deadline;
            timer_id_in = cmd.new_id;
         end
      end else if (cmd.pop || (cmd.remove && hit_through)) begin
         deadline_in = right_link.deadline;
         timer_id_in = right_link.timer_id;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      timer_id_ff <= timer_id_in;
   end

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// A request's response is registered in the output stage or, when that is full, in the skid stage.
// Throughput: one request per cycle while req_stall is low; the row of cells applies each insert, cancel or pop.
// A two-deep output stage lets one request be taken while a response waits.
// Reset (synchronous, active high) empties the queue, zeroes the id counter and drops
// pending responses; cell contents are left as they are.
`include "assert_macros.svh"

module sorted_timer_queue
   import stq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [TICK_W-1:0] req_deadline,
   input  logic [ID_W-1:0]   req_timer_id,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_result_id,
   output logic [TICK_W-1:0] rsp_result_deadline
);

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]    id_counter_ff, id_counter_in;
   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_type            out_ff, out_in;
   rsp_type            skid_ff, skid_in;

   logic               accept;
   logic               out_take;
   logic               is_empty;
   logic               is_full;
   logic               found;
   cell_cmd_type       cmd;
   rsp_type            rsp_new;
   logic [TICK_W-1:0]  cancel_deadline;

   cell_link_type      links [QUEUE_DEPTH];
   logic               hits [QUEUE_DEPTH+1];
   logic               first_hits [QUEUE_DEPTH];
   logic               cell_valid [QUEUE_DEPTH];

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign hits[0]   = 1'b0;
   assign found     = hits[QUEUE_DEPTH];

   // Row of cells, front (earliest deadline) at index zero.
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;

      assign cell_valid[k] = (count_ff > COUNT_W'(k));

      if (k == 0) begin : g_front
         assign left_link = '0;
      end else begin : g_inner
         assign left_link = links[k-1];
      end

      if (k == QUEUE_DEPTH - 1) begin : g_back
         assign right_link = '0;
      end else begin : g_body
         assign right_link = links[k+1];
      end

      stq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_valid (cell_valid[k]),
         .left_link  (left_link),
         .right_link (right_link),
         .hit_in     (hits[k]),
         .self_link  (links[k]),
         .hit_out    (hits[k+1]),
         .first_hit  (first_hits[k])
      );
   end

   // Deadline of the matching entry nearest the front.
   always_comb begin
      cancel_deadline = '0;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (first_hits[k]) begin
            cancel_deadline = cancel_deadline | links[k].deadline;
         end
      end
   end

   // Decode the request into a cell command, its response and the counters.
   always_comb begin
      cmd.insert    = 1'b0;
      cmd.remove    = 1'b0;
      cmd.pop       = 1'b0;
      cmd.deadline  = req_deadline;
      cmd.new_id    = id_counter_ff;
      cmd.timer_id  = req_timer_id;
      rsp_new       = '{status: ST_OK, result_id: '0, result_deadline: '0};
      count_in      = count_ff;
      id_counter_in = id_counter_ff;
      case (req_operation)
         OP_SCHEDULE: begin
            if (is_full) begin
               rsp_new.status = ST_FULL;
            end else begin
               cmd.insert        = accept;
               rsp_new.result_id = id_counter_ff;
               if (accept) begin
                  count_in      = count_ff + COUNT_W'(1);
                  id_counter_in = id_counter_ff + ID_W'(1);
               end
            end
         end
         OP_CANCEL: begin
            if (found) begin
               cmd.remove              = accept;
               rsp_new.result_id       = req_timer_id;
               rsp_new.result_deadline = cancel_deadline;
               if (accept) begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end else begin
               rsp_new.status = ST_NOT_FOUND;
            end
         end
         OP_POP: begin
            if (is_empty) begin
               rsp_new.status = ST_EMPTY;
            end else begin
               cmd.pop                 = accept;
               rsp_new.result_id       = links[0].timer_id;
               rsp_new.result_deadline = links[0].deadline;
               if (accept) begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
         end
         default: begin
            rsp_new = '{status: ST_OK, result_id: '0, result_deadline: '0};
         end
      endcase
   end

   // Output register with a skid stage behind it.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_in       = rsp_new;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = rsp_new;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         id_counter_ff <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         id_counter_ff <= id_counter_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_result_id       = out_ff.result_id;
   assign rsp_result_deadline = out_ff.result_deadline;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= COUNT_W'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff)
   `ASSERT_NEXT(a_pop_shrinks, clock, reset, accept && (req_operation == OP_POP) && !is_empty, count_ff == $past(count_ff) - COUNT_W'(1))
   `ASSERT_NEXT(a_schedule_id_step, clock, reset, accept && (req_operation == OP_SCHEDULE) && !is_full, id_counter_ff == $past(id_counter_ff) + ID_W'(1))
   `ASSERT_NEXT(a_held_response, clock, reset, out_valid_ff && rsp_stall, out_valid_ff && (out_ff == $past(out_ff)))

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import stq_pkg::*;

   localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int RANDOM_REQUESTS = 1950;
   localparam int QUIET_FIRST = 600;
   localparam int QUIET_LAST = 900;

   typedef struct {
      logic [1:0]        operation;
      logic [TICK_W-1:0] deadline;
      logic [ID_W-1:0]   timer_id;
      bit                drain_first;
   } timer_request_type;

   typedef struct {
      status_type        status;
      logic [ID_W-1:0]   result_id;
      logic [TICK_W-1:0] result_deadline;
   } timer_result_type;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_CANCEL} mix_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_operation = OP_SCHEDULE;
   logic [TICK_W-1:0] req_deadline = '0;
   logic [ID_W-1:0]   req_timer_id = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [ID_W-1:0]   rsp_result_id;
   logic [TICK_W-1:0] rsp_result_deadline;

   // Shadow copy of the timer queue, earliest deadline at index zero.
   logic [TICK_W-1:0] shadow_deadline [QUEUE_DEPTH];
   logic [ID_W-1:0]   shadow_id [QUEUE_DEPTH];
   int                shadow_count = 0;
   logic [ID_W-1:0]   shadow_next_id = '0;

   timer_request_type pending_requests [$];
   timer_result_type  expected_results [$];
   timer_request_type active_req;
   int                req_accepted = 0;
   int                rsp_done = 0;
   int                errors = 0;

   sorted_timer_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_deadline       (req_deadline),
      .req_timer_id       (req_timer_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_result_id      (rsp_result_id),
      .rsp_result_deadline(rsp_result_deadline)
   );

   always #10 clock = ~clock;

   // Apply one accepted request to the shadow queue and return its response.
   function automatic timer_result_type apply_timer_request(timer_request_type r);
      timer_result_type res;
      int               k;
      int               hit;
      res.status = ST_OK;
      res.result_id = '0;
      res.result_deadline = '0;
      hit = -1;
      case (r.operation)
         OP_SCHEDULE: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // Later deadlines move back one slot; ties stay ahead of the new entry.
               k = shadow_count;
               while (k > 0 && shadow_deadline[k-1] > r.deadline) begin
                  shadow_deadline[k] = shadow_deadline[k-1];
                  shadow_id[k] = shadow_id[k-1];
                  k--;
               end
               shadow_deadline[k] = r.deadline;
               shadow_id[k] = shadow_next_id;
               res.result_id = shadow_next_id;
               shadow_next_id = shadow_next_id + 1'b1;
               shadow_count++;
            end
         end
         OP_CANCEL, OP_POP: begin
            if (r.operation == OP_POP) begin
               if (shadow_count == 0) res.status = ST_EMPTY;
               else hit = 0;
            end else begin
               res.status = ST_NOT_FOUND;
               for (k = 0; k < shadow_count; k++) begin
                  if (hit < 0 && shadow_id[k] == r.timer_id) hit = k;
               end
            end
            if (hit >= 0) begin
               res.status = ST_OK;
               res.result_id = shadow_id[hit];
               res.result_deadline = shadow_deadline[hit];
               for (k = hit; k < shadow_count - 1; k++) begin
                  shadow_deadline[k] = shadow_deadline[k+1];
                  shadow_id[k] = shadow_id[k+1];
               end
               shadow_count--;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic add_request(logic [1:0] op, logic [TICK_W-1:0] dl,
                              logic [ID_W-1:0] tid, bit drain);
      timer_request_type r;
      r.operation = op;
      r.deadline = dl;
      r.timer_id = tid;
      r.drain_first = drain;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   // Request driver: predicts each accepted request and presents the next one.
   always @(posedge clock) begin
      bit quiet;
      bit hold;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.insert(expected_results.size(),
                                    apply_timer_request(active_req));
            req_accepted++;
         end
         if (!req_valid || !req_stall) begin
            quiet = req_accepted >= QUIET_FIRST && req_accepted < QUIET_LAST;
            hold = pending_requests.size() == 0;
            if (!hold) begin
               hold = (pending_requests[0].drain_first && rsp_done != req_accepted) ||
                      (!quiet && $urandom_range(99) < 14);
            end
            if (hold) begin
               req_valid <= 1'b0;
            end else begin
               active_req = pending_requests.pop_front();
               req_operation <= active_req.operation;
               req_deadline <= active_req.deadline;
               req_timer_id <= active_req.timer_id;
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Response monitor: checks each accepted response against the oldest prediction.
   always @(posedge clock) begin
      timer_result_type exp_res;
      bit               quiet;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("response with no request waiting: status %0d id %h deadline %h",
                      rsp_status, rsp_result_id, rsp_result_deadline);
               errors++;
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_status !== exp_res.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         exp_res.status, rsp_status);
                  errors++;
               end
               if (rsp_result_id !== exp_res.result_id) begin
                  $error("result_id mismatch: expected %h, actual %h",
                         exp_res.result_id, rsp_result_id);
                  errors++;
               end
               if (rsp_result_deadline !== exp_res.result_deadline) begin
                  $error("result_deadline mismatch: expected %h, actual %h",
                         exp_res.result_deadline, rsp_result_deadline);
                  errors++;
               end
            end
            rsp_done <= rsp_done + 1;
         end
         quiet = rsp_done >= QUIET_FIRST && rsp_done < QUIET_LAST;
         rsp_stall <= !quiet && $urandom_range(99) < 14;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int      n;
      int      i;
      int      seg_len;
      int      roll;
      int      pct_sched;
      int      pct_pop;
      int      pct_cancel;
      int      issued;
      bit      first;
      bit      mid_pause;
      bit      drain;
      mix_type mode;
      logic [1:0]        op;
      logic [TICK_W-1:0] dl;
      logic [ID_W-1:0]   tid;

      // Directed: empty queue, reserved code, extremes, ties and cancels.
      add_request(OP_POP, '0, '0, 1'b0);
      add_request(OP_CANCEL, '0, '0, 1'b0);
      add_request(OP_RESERVED, '1, '1, 1'b0);
      add_request(OP_SCHEDULE, 32'hFFFF_FFFF, '0, 1'b0);
      add_request(OP_SCHEDULE, 32'h0, '1, 1'b0);
      add_request(OP_SCHEDULE, 32'd5, '0, 1'b0);
      add_request(OP_SCHEDULE, 32'd5, '0, 1'b0);
      add_request(OP_SCHEDULE, 32'd5, '0, 1'b0);
      add_request(OP_CANCEL, '0, 32'd3, 1'b0);
      add_request(OP_CANCEL, '0, 32'hFFFF_FFFF, 1'b0);
      add_request(OP_CANCEL, '0, 32'd3, 1'b0);
      add_request(OP_RESERVED, 32'h1234_5678, 32'd1, 1'b0);
      add_request(OP_POP, '1, '1, 1'b0);
      add_request(OP_POP, '0, '0, 1'b0);
      add_request(OP_POP, '0, '0, 1'b0);
      add_request(OP_POP, '0, '0, 1'b0);
      add_request(OP_POP, '0, '0, 1'b0);
      add_request(OP_SCHEDULE, 32'h7FFF_FFFF, '0, 1'b0);
      add_request(OP_SCHEDULE, 32'h8000_0000, '0, 1'b0);
      add_request(OP_CANCEL, '0, 32'd6, 1'b0);
      add_request(OP_CANCEL, '0, 32'd5, 1'b0);
      issued = 7;

      // Random segments, each with its own operation mix; the first one fills
      // the queue past full.
      n = 0;
      first = 1'b1;
      mid_pause = 1'b0;
      while (n < RANDOM_REQUESTS) begin
         mode = first ? MIX_FILL : mix_type'($urandom_range(3));
         seg_len = (mode == MIX_FILL) ? 90 : $urandom_range(120, 30);
         case (mode)
            MIX_FILL:     begin pct_sched = 93; pct_pop = 3;  pct_cancel = 3;  end
            MIX_DRAIN:    begin pct_sched = 15; pct_pop = 60; pct_cancel = 24; end
            MIX_BALANCED: begin pct_sched = 40; pct_pop = 30; pct_cancel = 27; end
            default:      begin pct_sched = 45; pct_pop = 10; pct_cancel = 44; end
         endcase
         for (i = 0; i < seg_len; i++) begin
            roll = $urandom_range(99);
            if (roll < pct_sched) op = OP_SCHEDULE;
            else if (roll < pct_sched + pct_pop) op = OP_POP;
            else if (roll < pct_sched + pct_pop + pct_cancel) op = OP_CANCEL;
            else op = OP_RESERVED;

            // Small deadlines give many ties; a few land on the extremes.
            roll = $urandom_range(99);
            if (roll < 30) begin
               dl = $urandom_range(7);
            end else if (roll < 40) begin
               case ($urandom_range(3))
                  0: dl = 32'h0;
                  1: dl = 32'hFFFF_FFFF;
                  2: dl = 32'h7FFF_FFFF;
                  default: dl = 32'h8000_0000;
               endcase
            end else begin
               dl = $urandom;
            end

            // Cancels mostly aim at recently issued ids, some of them gone.
            roll = $urandom_range(99);
            if (op == OP_CANCEL && roll < 70) begin
               tid = issued - 1 - $urandom_range(issued > 80 ? 79 : issued - 1);
            end else if (op == OP_CANCEL && roll < 90) begin
               tid = $urandom_range(issued);
            end else begin
               tid = $urandom;
            end

            drain = 1'b0;
            if (i == 0 && first) drain = 1'b1;
            if (i == 0 && !mid_pause && n >= RANDOM_REQUESTS / 2) begin
               drain = 1'b1;
               mid_pause = 1'b1;
            end
            add_request(op, dl, tid, drain);
            if (op == OP_SCHEDULE) issued++;
            if (op != OP_RESERVED) n++;
         end
         first = 1'b0;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d responses never arrived", expected_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_timer_queue.sv
tb/tb_top.sv
